>>> hw/rtl/dvbp_pkg.sv
// ----------------------------------------------------------------------------
// Deepest vertex below plane: shared package
// Widths, register indexes and the types passed between the core and the
// dot-product stage.
// ----------------------------------------------------------------------------
package dvbp_pkg;

  // Coordinate and normal formats.
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned NORM_FRAC = 16;
  localparam int unsigned NORM_W    = NORM_FRAC + 2;

  // Arithmetic widths of the distance path.
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + NORM_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned SHIFT_W = SUM_W - NORM_FRAC;
  localparam int unsigned DEPTH_W = COORD_W + 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = COORD_W;

  // Stream payload widths.
  localparam int unsigned IN_DATA_W  = 3 * COORD_W;
  localparam int unsigned OUT_DATA_W = 3 * COORD_W + DEPTH_W;

  // One in the normal format, used as the y component of the reset normal.
  localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1) << NORM_FRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_X = 3'd0,
    REG_PLANE_Y = 3'd1,
    REG_PLANE_Z = 3'd2,
    REG_NORM_X  = 3'd3,
    REG_NORM_Y  = 3'd4,
    REG_NORM_Z  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nz;
  } plane_t;

  // Plane after reset: point at the origin, normal along +y.
  localparam plane_t PLANE_RESET = '{px: '0, py: '0, pz: '0,
                                     nx: '0, ny: NORM_ONE, nz: '0};

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
    logic signed [PROD_W-1:0] pz;
  } prod_t;

endpackage

>>> hw/rtl/dvbp_dot.sv
// ----------------------------------------------------------------------------
// Deepest vertex below plane: per-axis products
// Forms (v - p) * n for each axis, exact, ahead of the product register.
// ----------------------------------------------------------------------------
module dvbp_dot (
  input  dvbp_pkg::plane_t  plane_i,
  input  dvbp_pkg::vertex_t vtx_i,
  output dvbp_pkg::prod_t   prod_o
);

  logic signed [dvbp_pkg::DIFF_W-1:0] diff_x;
  logic signed [dvbp_pkg::DIFF_W-1:0] diff_y;
  logic signed [dvbp_pkg::DIFF_W-1:0] diff_z;

  // Offsets from the plane point, one bit wider so they never wrap.
  assign diff_x = $signed({vtx_i.x[dvbp_pkg::COORD_W-1], vtx_i.x})
                - $signed({plane_i.px[dvbp_pkg::COORD_W-1], plane_i.px});
  assign diff_y = $signed({vtx_i.y[dvbp_pkg::COORD_W-1], vtx_i.y})
                - $signed({plane_i.py[dvbp_pkg::COORD_W-1], plane_i.py});
  assign diff_z = $signed({vtx_i.z[dvbp_pkg::COORD_W-1], vtx_i.z})
                - $signed({plane_i.pz[dvbp_pkg::COORD_W-1], plane_i.pz});

  // One signed multiplier per axis, full product width.
  always_comb begin
    prod_o.px = dvbp_pkg::PROD_W'(diff_x) * dvbp_pkg::PROD_W'(plane_i.nx);
    prod_o.py = dvbp_pkg::PROD_W'(diff_y) * dvbp_pkg::PROD_W'(plane_i.ny);
    prod_o.pz = dvbp_pkg::PROD_W'(diff_z) * dvbp_pkg::PROD_W'(plane_i.nz);
  end

endmodule

>>> hw/rtl/deepest_vertex_below_plane_core.sv
// ----------------------------------------------------------------------------
// Deepest vertex below plane: core
// Streams a body's vertices, tracks the most negative signed plane distance
// and reports that vertex and its depth on the last vertex of the body.
// ----------------------------------------------------------------------------
// A body's last vertex moves through the input, product and result registers.
// Throughput: one vertex per cycle unless a last vertex waits for room in the
// result register; the three axis multipliers sit between the input and
// product registers, the sum and running minimum after them.
// Reset: the plane point clears to zero, the normal to +y, the tracker to
// no contact, and all pipeline stages to empty.
module deepest_vertex_below_plane_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [dvbp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dvbp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Vertex stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: vertex_x, vertex_y, vertex_z (lowest bits first)
  input  logic [dvbp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,
  // Contact stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: contact_x, contact_y, contact_z, penetration_depth (lowest first)
  output logic [dvbp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: contact_found
  output logic                              m_axis_tuser
);

  localparam int unsigned CW = dvbp_pkg::COORD_W;
  localparam int unsigned DW = dvbp_pkg::DEPTH_W;
  localparam int unsigned SW = dvbp_pkg::SUM_W;
  localparam int unsigned FB = dvbp_pkg::NORM_FRAC;

  // Configuration registers.
  dvbp_pkg::plane_t plane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= dvbp_pkg::PLANE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dvbp_pkg::REG_PLANE_X: plane_q.px <= cfg_wdata_i[CW-1:0];
        dvbp_pkg::REG_PLANE_Y: plane_q.py <= cfg_wdata_i[CW-1:0];
        dvbp_pkg::REG_PLANE_Z: plane_q.pz <= cfg_wdata_i[CW-1:0];
        dvbp_pkg::REG_NORM_X:  plane_q.nx <= cfg_wdata_i[dvbp_pkg::NORM_W-1:0];
        dvbp_pkg::REG_NORM_Y:  plane_q.ny <= cfg_wdata_i[dvbp_pkg::NORM_W-1:0];
        dvbp_pkg::REG_NORM_Z:  plane_q.nz <= cfg_wdata_i[dvbp_pkg::NORM_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake. Only last vertices need room in the result register.
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_last_q, s2_last_q;
  logic out_ready, s2_fire, s2_ready, s1_ready, s_fire;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s2_fire       = s2_valid_q && (!s2_last_q || out_ready);
  assign s2_ready      = !s2_valid_q || s2_fire;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign s_fire        = s_axis_tvalid && s1_ready;

  // Input register.
  dvbp_pkg::vertex_t s1_vtx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_vtx_q.x <= s_axis_tdata[CW-1:0];
      s1_vtx_q.y <= s_axis_tdata[2*CW-1:CW];
      s1_vtx_q.z <= s_axis_tdata[3*CW-1:2*CW];
      s1_last_q  <= s_axis_tlast;
    end
  end

  // Product stage.
  dvbp_pkg::prod_t   prod_d;
  dvbp_pkg::prod_t   s2_prod_q;
  dvbp_pkg::vertex_t s2_vtx_q;

  dvbp_dot u_dot (
    .plane_i (plane_q),
    .vtx_i   (s1_vtx_q),
    .prod_o  (prod_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_prod_q <= prod_d;
      s2_vtx_q  <= s1_vtx_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Sum, floor shift to Q16.16 and running minimum.
  logic signed [SW-1:0] dot_sum;
  logic signed [DW-1:0] plane_dist;
  logic                 below;
  logic                 take;
  logic                 have_q, have_d;
  logic signed [DW-1:0] best_depth_q, best_depth_d;
  dvbp_pkg::vertex_t    best_vtx_q, best_vtx_d;

  assign dot_sum    = SW'(s2_prod_q.px) + SW'(s2_prod_q.py) + SW'(s2_prod_q.pz);
  assign plane_dist = {{(DW - dvbp_pkg::SHIFT_W){dot_sum[SW-1]}}, dot_sum[SW-1:FB]};
  assign below      = dot_sum[SW-1];
  // An equal depth keeps the earlier vertex.
  assign take       = below && (!have_q || (plane_dist < best_depth_q));

  always_comb begin
    have_d       = have_q || take;
    best_depth_d = take ? plane_dist : best_depth_q;
    best_vtx_d   = take ? s2_vtx_q : best_vtx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q       <= 1'b0;
      best_depth_q <= '0;
      best_vtx_q   <= '0;
    end else if (s2_fire) begin
      if (s2_last_q) begin
        have_q       <= 1'b0;
        best_depth_q <= '0;
        best_vtx_q   <= '0;
      end else begin
        have_q       <= have_d;
        best_depth_q <= best_depth_d;
        best_vtx_q   <= best_vtx_d;
      end
    end
  end

  // Result register.
  logic                 out_found_q;
  dvbp_pkg::vertex_t    out_vtx_q;
  logic signed [DW-1:0] out_depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s2_fire && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s2_fire && s2_last_q) begin
      out_found_q <= have_d;
      out_vtx_q   <= best_vtx_d;
      out_depth_q <= best_depth_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {out_depth_q, out_vtx_q.z, out_vtx_q.y, out_vtx_q.x};

  // A body's last vertex always yields a transaction on the next cycle.
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire && s2_last_q |=> m_axis_tvalid)
    else $error("last vertex did not produce a contact transaction");

  // The tracker starts clean for the next body.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire && s2_last_q |=> !have_q)
    else $error("contact state not cleared after last vertex");

  // Without a contact, every payload field is zero.
  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("payload not zero without a contact");

  // A reported contact always lies strictly below the plane.
  a_depth_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> out_depth_q[DW-1])
    else $error("reported contact depth is not negative");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deepest vertex below plane: regression testbench
// Streams bodies of vertices into the core under several plane settings. A
// behavioral tracker mirrors the signed-distance search for each accepted
// vertex and queues the contact expected at the end of each body. A monitor
// compares every contact transaction against that queue, field by field.
// ----------------------------------------------------------------------------
module testbench;

  // Spare register slots that the core must ignore.
  localparam logic [dvbp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [dvbp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [dvbp_pkg::COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [dvbp_pkg::COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [dvbp_pkg::NORM_W-1:0]  NORM_MAX  = 18'sh1_FFFF;
  localparam logic signed [dvbp_pkg::NORM_W-1:0]  NORM_MIN  = 18'sh2_0000;
  localparam longint DEPTH_FLOOR = -(longint'(1) << (dvbp_pkg::DEPTH_W - 1));
  localparam int IDLE_PCT = 18;

  typedef struct packed {
    logic                                found;
    dvbp_pkg::vertex_t                   v;
    logic signed [dvbp_pkg::DEPTH_W-1:0] depth;
  } contact_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [dvbp_pkg::CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [dvbp_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [dvbp_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            s_axis_tlast  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [dvbp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  // Mirror of the plane registers and of the deepest-vertex tracker.
  dvbp_pkg::plane_t  plane_cfg;
  bit                have_contact;
  longint            best_depth;
  dvbp_pkg::vertex_t best_vertex;
  contact_t          contact_q[$];

  bit no_idle = 1'b0;
  int mismatches = 0;
  int vertices_sent = 0;
  int contacts_checked = 0;
  int contacts_found = 0;
  int planes_programmed = 0;

  deepest_vertex_below_plane_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Absolute limit on the run.
  initial begin
    #2_000_000;
    $display("deepest_vertex_below_plane_core regression: fail");
    $finish;
  end

  // Random back-pressure on the contact stream.
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Signed distance of a vertex from the current plane, floored to Q16.16.
  function automatic longint signed_distance(dvbp_pkg::vertex_t v);
    longint dot;
    dot = (longint'($signed(v.x)) - longint'($signed(plane_cfg.px)))
          * longint'($signed(plane_cfg.nx))
        + (longint'($signed(v.y)) - longint'($signed(plane_cfg.py)))
          * longint'($signed(plane_cfg.ny))
        + (longint'($signed(v.z)) - longint'($signed(plane_cfg.pz)))
          * longint'($signed(plane_cfg.nz));
    return dot >>> dvbp_pkg::NORM_FRAC;
  endfunction

  // Update the deepest-vertex search and queue a contact at the end of a body.
  function automatic void track_vertex(dvbp_pkg::vertex_t v, bit last);
    longint   d;
    contact_t c;
    d = signed_distance(v);
    if (d < 0) begin
      if (d < DEPTH_FLOOR) d = DEPTH_FLOOR;
      // A tie keeps the earlier vertex.
      if (!have_contact || d < best_depth) begin
        have_contact = 1'b1;
        best_depth   = d;
        best_vertex  = v;
      end
    end
    if (last) begin
      c.found = have_contact;
      c.v     = best_vertex;
      c.depth = best_depth[dvbp_pkg::DEPTH_W-1:0];
      contact_q.insert(contact_q.size(), c);
      have_contact = 1'b0;
      best_depth   = 0;
      best_vertex  = '0;
    end
  endfunction

  function automatic dvbp_pkg::vertex_t mk_vertex(logic signed [dvbp_pkg::COORD_W-1:0] x,
                                                  logic signed [dvbp_pkg::COORD_W-1:0] y,
                                                  logic signed [dvbp_pkg::COORD_W-1:0] z);
    dvbp_pkg::vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  function automatic dvbp_pkg::plane_t mk_plane(logic signed [dvbp_pkg::COORD_W-1:0] px,
                                                logic signed [dvbp_pkg::COORD_W-1:0] py,
                                                logic signed [dvbp_pkg::COORD_W-1:0] pz,
                                                logic signed [dvbp_pkg::NORM_W-1:0] nx,
                                                logic signed [dvbp_pkg::NORM_W-1:0] ny,
                                                logic signed [dvbp_pkg::NORM_W-1:0] nz);
    dvbp_pkg::plane_t p;
    p.px = px;
    p.py = py;
    p.pz = pz;
    p.nx = nx;
    p.ny = ny;
    p.nz = nz;
    return p;
  endfunction

  // Send one vertex, with random idle cycles ahead of it unless no_idle is set.
  task automatic send_vertex(input dvbp_pkg::vertex_t v, input bit last);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v.z, v.y, v.x};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_vertex(v, last);
    vertices_sent++;
  endtask

  // Stop sending and let every expected contact and the pipeline drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the write enable afterwards.
  task automatic write_reg(input logic [dvbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dvbp_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      dvbp_pkg::REG_PLANE_X: plane_cfg.px = data;
      dvbp_pkg::REG_PLANE_Y: plane_cfg.py = data;
      dvbp_pkg::REG_PLANE_Z: plane_cfg.pz = data;
      dvbp_pkg::REG_NORM_X:  plane_cfg.nx = data[dvbp_pkg::NORM_W-1:0];
      dvbp_pkg::REG_NORM_Y:  plane_cfg.ny = data[dvbp_pkg::NORM_W-1:0];
      dvbp_pkg::REG_NORM_Z:  plane_cfg.nz = data[dvbp_pkg::NORM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_plane(input dvbp_pkg::plane_t p);
    settle();
    write_reg(dvbp_pkg::REG_PLANE_X, p.px);
    write_reg(dvbp_pkg::REG_PLANE_Y, p.py);
    write_reg(dvbp_pkg::REG_PLANE_Z, p.pz);
    write_reg(dvbp_pkg::REG_NORM_X, dvbp_pkg::CFG_DATA_W'(p.nx));
    write_reg(dvbp_pkg::REG_NORM_Y, dvbp_pkg::CFG_DATA_W'(p.ny));
    write_reg(dvbp_pkg::REG_NORM_Z, dvbp_pkg::CFG_DATA_W'(p.nz));
    cfg_we_i <= 1'b0;
    planes_programmed++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Contact checker.
  always @(posedge clk_i) begin
    contact_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (contact_q.size() == 0) begin
        $display("%0t: unexpected contact transaction, expected none, got found=%0b",
                 $time, m_axis_tuser);
        mismatches++;
      end else begin
        want = contact_q.pop_front();
        check_field("contact_found", 64'(want.found), 64'(m_axis_tuser));
        check_field("contact_x", 64'(want.v.x),
                    64'($signed(m_axis_tdata[dvbp_pkg::COORD_W-1:0])));
        check_field("contact_y", 64'(want.v.y),
                    64'($signed(m_axis_tdata[2*dvbp_pkg::COORD_W-1:dvbp_pkg::COORD_W])));
        check_field("contact_z", 64'(want.v.z),
                    64'($signed(m_axis_tdata[3*dvbp_pkg::COORD_W-1:2*dvbp_pkg::COORD_W])));
        check_field("penetration_depth", 64'(want.depth),
                    64'($signed(m_axis_tdata[dvbp_pkg::OUT_DATA_W-1:3*dvbp_pkg::COORD_W])));
        contacts_checked++;
        if (want.found) contacts_found++;
      end
    end
  end

  // Plane after reset: the point at the origin and the normal along +y.
  task automatic test_reset_plane();
    // Ties on the deepest distance keep the first vertex.
    send_vertex(mk_vertex(0, 0, 0), 1'b0);
    send_vertex(mk_vertex(5, -3, 7), 1'b0);
    send_vertex(mk_vertex(9, -3, 1), 1'b0);
    send_vertex(mk_vertex(1, 2, 3), 1'b1);
    // A vertex exactly on the plane does not penetrate it.
    send_vertex(mk_vertex(100, 0, -100), 1'b1);
    // A later, deeper vertex replaces the current best.
    send_vertex(mk_vertex(-7, -1, 7), 1'b0);
    send_vertex(mk_vertex(4, -2, 4), 1'b0);
    send_vertex(mk_vertex(3, 5, 0), 1'b1);
  endtask

  // Plane points, normals and vertices at the ends of their ranges.
  task automatic test_extreme_planes();
    program_plane(mk_plane(COORD_MAX, COORD_MAX, COORD_MAX, NORM_MAX, NORM_MAX, NORM_MAX));
    send_vertex(mk_vertex(COORD_MIN, COORD_MIN, COORD_MIN), 1'b0);
    send_vertex(mk_vertex(COORD_MAX, COORD_MAX, COORD_MAX), 1'b1);
    program_plane(mk_plane(COORD_MAX, COORD_MAX, COORD_MAX, NORM_MIN, NORM_MIN, NORM_MIN));
    send_vertex(mk_vertex(COORD_MIN, COORD_MIN, COORD_MIN), 1'b1);
    program_plane(mk_plane(COORD_MIN, COORD_MIN, COORD_MIN, NORM_MIN, NORM_MIN, NORM_MIN));
    send_vertex(mk_vertex(COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
    send_vertex(mk_vertex(COORD_MIN, COORD_MIN, COORD_MIN), 1'b1);
    program_plane(mk_plane(COORD_MIN, COORD_MIN, COORD_MIN, NORM_MAX, NORM_MAX, NORM_MAX));
    send_vertex(mk_vertex(COORD_MAX, COORD_MAX, COORD_MAX), 1'b1);
  endtask

  // A dot product just below zero floors to -1; a zero normal never penetrates.
  task automatic test_tiny_dot_and_flat_normal();
    program_plane(mk_plane(0, 0, 0, 1, 0, 0));
    send_vertex(mk_vertex(-1, COORD_MAX, COORD_MIN), 1'b1);
    program_plane(mk_plane(0, 0, 0, 0, 0, 0));
    send_vertex(mk_vertex(COORD_MIN, COORD_MIN, COORD_MIN), 1'b1);
  endtask

  // Writes to unused register slots must leave the plane untouched.
  task automatic test_spare_index();
    program_plane(mk_plane(0, 0, 0, 0, 0, dvbp_pkg::NORM_ONE));
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    cfg_we_i <= 1'b0;
    send_vertex(mk_vertex(COORD_MAX, COORD_MIN, -65536), 1'b1);
  endtask

  function automatic logic signed [dvbp_pkg::NORM_W-1:0] rand_normal_axis(int style);
    case (style)
      0: return ($urandom_range(1)) ? dvbp_pkg::NORM_ONE : -dvbp_pkg::NORM_ONE;
      1: return dvbp_pkg::NORM_W'($urandom);
      default: return ($urandom_range(1)) ? NORM_MAX : NORM_MIN;
    endcase
  endfunction

  function automatic dvbp_pkg::plane_t rand_plane(int style);
    dvbp_pkg::plane_t p;
    int               axis;
    p.px = ($urandom_range(1)) ? $urandom : $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    p.py = ($urandom_range(1)) ? $urandom : $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    p.pz = ($urandom_range(1)) ? $urandom : $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    p.nx = rand_normal_axis(style);
    p.ny = rand_normal_axis(style);
    p.nz = rand_normal_axis(style);
    // Axis-aligned planes keep a single nonzero normal component.
    if (style == 0) begin
      axis = $urandom_range(2);
      if (axis != 0) p.nx = '0;
      if (axis != 1) p.ny = '0;
      if (axis != 2) p.nz = '0;
    end
    return p;
  endfunction

  function automatic logic signed [dvbp_pkg::COORD_W-1:0] rand_coord(
      logic signed [dvbp_pkg::COORD_W-1:0] center);
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return center + ($urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000);
    if (pick < 85) return $urandom;
    case ($urandom_range(3))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  // Random bodies under a series of random planes.
  task automatic test_random_bodies();
    dvbp_pkg::vertex_t v;
    dvbp_pkg::vertex_t prev;
    int                last_pct;
    int                budget;
    prev = '0;
    for (int phase = 0; phase < 8; phase++) begin
      program_plane(rand_plane(phase % 3));
      // One phase runs both streams at full rate.
      no_idle  = (phase == 3);
      last_pct = (phase % 4 == 1) ? 50 : ((phase % 4 == 2) ? 5 : 17);
      budget   = 244;
      while (budget > 0) begin
        // Repeated vertices can produce ties on the deepest distance.
        if ($urandom_range(19) == 0) v = prev;
        else v = mk_vertex(rand_coord(plane_cfg.px), rand_coord(plane_cfg.py),
                           rand_coord(plane_cfg.pz));
        send_vertex(v, $urandom_range(99) < last_pct);
        prev = v;
        budget--;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    plane_cfg    = mk_plane(0, 0, 0, 0, dvbp_pkg::NORM_ONE, 0);
    have_contact = 1'b0;
    best_depth   = 0;
    best_vertex  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_plane();
    test_extreme_planes();
    test_tiny_dot_and_flat_normal();
    test_spare_index();
    test_random_bodies();

    s_axis_tvalid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Streamed %0d vertices under %0d plane settings; checked %0d contacts,",
             vertices_sent, planes_programmed, contacts_checked);
    $display("%0d of them with a penetrating vertex, with %0d mismatches.",
             contacts_found, mismatches);
    if (mismatches == 0) begin
      $display("deepest_vertex_below_plane_core regression: pass");
    end else begin
      $display("deepest_vertex_below_plane_core regression: fail");
    end
    $finish;
  end

endmodule
